// File: src/stationary_gyro_bias_averager_top_assert.svh
// ----------------------------------------------------------------------------
// stationary_gyro_bias_averager_top_assert.svh
// assertion macros shared by the averager top level
// ----------------------------------------------------------------------------
`ifndef STATIONARY_GYRO_BIAS_AVERAGER_TOP_ASSERT_SVH
`define STATIONARY_GYRO_BIAS_AVERAGER_TOP_ASSERT_SVH

// condition must never hold outside reset
`define SGBA_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SGBA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SGBA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/sgba_pkg.sv
// ----------------------------------------------------------------------------
// sgba_pkg
// shared constants, codes and control types of the gyro bias averager
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgba_pkg;

   // field widths
   localparam int RATE_W     = 32;
   localparam int LIMIT_W    = 31;
   localparam int SAMPLE_W   = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // default count width
   localparam int COUNT_BITS_DEF = 16;

   // register reset values
   localparam logic [LIMIT_W-1:0] VEL_LIMIT_RESET = 31'd1;
   localparam logic [LIMIT_W-1:0] YAW_LIMIT_RESET = 31'd32768;

   // register index, taken from the word address bit
   localparam logic CSR_VEL_LIMIT = 1'b0;
   localparam logic CSR_YAW_LIMIT = 1'b1;

   // input beat kinds
   localparam logic KIND_WHEEL = 1'b0;
   localparam logic KIND_GYRO  = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PITCH_GO,
      ST_PITCH_WAIT,
      ST_YAW_WAIT,
      ST_PUBLISH
   } sgba_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div_start;
      logic div_yaw;
      logic take_pitch;
      logic publish;
   } sgba_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic out_free;
   } sgba_status_type;

endpackage

// File: src/sgba_div.sv
// ----------------------------------------------------------------------------
// sgba_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgba_div #(
   parameter int DIVIDEND_W = 48,
   parameter int DIVISOR_W  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // one restoring step
   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: src/sgba_datapath.sv
// ----------------------------------------------------------------------------
// sgba_datapath
// limits, running sums, count, shared divider and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgba_datapath #(
   parameter int COUNT_BITS = sgba_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // control
   input  sgba_pkg::sgba_cmd_type              cmd,
   output sgba_pkg::sgba_status_type           status,
   // input beat payload
   input  logic                                req_kind,
   input  logic [sgba_pkg::RATE_W-1:0]         req_velocity,
   input  logic [sgba_pkg::RATE_W-1:0]         req_pitch_rate,
   input  logic [sgba_pkg::RATE_W-1:0]         req_yaw_rate,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sgba_pkg::RATE_W-1:0]         rsp_pitch_average,
   output logic [sgba_pkg::RATE_W-1:0]         rsp_yaw_average,
   output logic [sgba_pkg::SAMPLE_W-1:0]       rsp_sample_count,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sgba_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sgba_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sgba_pkg::CSR_DATA_W-1:0]     csr_prdata
);

   localparam int RW   = sgba_pkg::RATE_W;
   localparam int LW   = sgba_pkg::LIMIT_W;
   localparam int SUMW = RW + COUNT_BITS;

   logic [LW-1:0]         vel_limit_ff, vel_limit_in;
   logic [LW-1:0]         yaw_limit_ff, yaw_limit_in;
   logic [RW-1:0]         last_vel_ff, last_vel_in;
   logic [SUMW-1:0]       pitch_sum_ff, pitch_sum_in;
   logic [SUMW-1:0]       yaw_sum_ff, yaw_sum_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [RW-1:0]         pitch_avg_ff, pitch_avg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]         rsp_pitch_ff, rsp_pitch_in;
   logic [RW-1:0]         rsp_yaw_ff, rsp_yaw_in;
   logic [sgba_pkg::SAMPLE_W-1:0] rsp_count_ff, rsp_count_in;

   logic            csr_write;
   logic [RW-1:0]   vel_mag, yaw_mag;
   logic            still;
   logic [SUMW-1:0] sel_sum;
   logic [SUMW-1:0] div_dividend;
   logic [SUMW-1:0] div_quotient;
   logic            div_busy, div_done;
   logic [RW-1:0]   quo_low;
   logic            quo_neg;
   logic [RW-1:0]   signed_avg;
   logic            out_free;

   // register writes and reads
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      vel_limit_in = vel_limit_ff;
      yaw_limit_in = yaw_limit_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            sgba_pkg::CSR_VEL_LIMIT: vel_limit_in = csr_pwdata[LW-1:0];
            sgba_pkg::CSR_YAW_LIMIT: yaw_limit_in = csr_pwdata[LW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         sgba_pkg::CSR_VEL_LIMIT: csr_prdata = {1'b0, vel_limit_ff};
         sgba_pkg::CSR_YAW_LIMIT: csr_prdata = {1'b0, yaw_limit_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // stationary test, most negative value gives magnitude 2^31
   assign vel_mag = last_vel_ff[RW-1] ? (~last_vel_ff + 1'b1) : last_vel_ff;
   assign yaw_mag = req_yaw_rate[RW-1] ? (~req_yaw_rate + 1'b1) : req_yaw_rate;
   assign still   = (vel_mag < {1'b0, vel_limit_ff}) && (yaw_mag < {1'b0, yaw_limit_ff});

   // state update on an accepted beat
   always_comb begin
      last_vel_in  = last_vel_ff;
      pitch_sum_in = pitch_sum_ff;
      yaw_sum_in   = yaw_sum_ff;
      count_in     = count_ff;
      if (cmd.load) begin
         if (req_kind == sgba_pkg::KIND_WHEEL) begin
            last_vel_in = req_velocity;
         end else if (still) begin
            // saturated count ignores the sample
            if (!(&count_ff)) begin
               pitch_sum_in = pitch_sum_ff + {{COUNT_BITS{req_pitch_rate[RW-1]}}, req_pitch_rate};
               yaw_sum_in   = yaw_sum_ff + {{COUNT_BITS{req_yaw_rate[RW-1]}}, req_yaw_rate};
               count_in     = count_ff + 1'b1;
            end
         end else begin
            pitch_sum_in = '0;
            yaw_sum_in   = '0;
            count_in     = '0;
         end
      end
   end

   // divider operand: magnitude of the selected sum
   assign sel_sum      = cmd.div_yaw ? yaw_sum_ff : pitch_sum_ff;
   assign div_dividend = sel_sum[SUMW-1] ? (~sel_sum + 1'b1) : sel_sum;

   sgba_div #(
      .DIVIDEND_W (SUMW),
      .DIVISOR_W  (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // restore the sign of the finished quotient, zero for an empty count
   assign quo_low = div_quotient[RW-1:0];

   // pitch sign while the pitch mean is taken, even as the yaw run is launched
   assign quo_neg = (cmd.div_yaw && !cmd.take_pitch) ? yaw_sum_ff[SUMW-1]
                                                     : pitch_sum_ff[SUMW-1];

   always_comb begin
      if (count_ff == '0) begin
         signed_avg = '0;
      end else if (quo_neg) begin
         signed_avg = ~quo_low + 1'b1;
      end else begin
         signed_avg = quo_low;
      end
   end

   assign pitch_avg_in = cmd.take_pitch ? signed_avg : pitch_avg_ff;

   // result register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pitch_in = rsp_pitch_ff;
      rsp_yaw_in   = rsp_yaw_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
         rsp_pitch_in = pitch_avg_ff;
         rsp_yaw_in   = signed_avg;
         rsp_count_in = sgba_pkg::SAMPLE_W'(count_ff);
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vel_limit_ff <= sgba_pkg::VEL_LIMIT_RESET;
         yaw_limit_ff <= sgba_pkg::YAW_LIMIT_RESET;
         last_vel_ff  <= '0;
         pitch_sum_ff <= '0;
         yaw_sum_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vel_limit_ff <= vel_limit_in;
         yaw_limit_ff <= yaw_limit_in;
         last_vel_ff  <= last_vel_in;
         pitch_sum_ff <= pitch_sum_in;
         yaw_sum_ff   <= yaw_sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pitch_avg_ff <= pitch_avg_in;
      rsp_pitch_ff <= rsp_pitch_in;
      rsp_yaw_ff   <= rsp_yaw_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign status.div_busy = div_busy;
   assign status.div_done = div_done;
   assign status.out_free = out_free;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pitch_average = rsp_pitch_ff;
   assign rsp_yaw_average   = rsp_yaw_ff;
   assign rsp_sample_count  = rsp_count_ff;

endmodule

// File: src/sgba_ctrl.sv
// ----------------------------------------------------------------------------
// sgba_ctrl
// sequencer: update, pitch division, yaw division, publish
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgba_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  sgba_pkg::sgba_status_type status,
   output sgba_pkg::sgba_cmd_type    cmd
);

   sgba_pkg::sgba_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgba_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.load       = 1'b0;
      cmd.div_start  = 1'b0;
      cmd.div_yaw    = 1'b0;
      cmd.take_pitch = 1'b0;
      cmd.publish    = 1'b0;
      case (state_ff)
         sgba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sgba_pkg::ST_PITCH_GO;
            end
         end
         sgba_pkg::ST_PITCH_GO: begin
            cmd.div_start = 1'b1;
            state_in      = sgba_pkg::ST_PITCH_WAIT;
         end
         sgba_pkg::ST_PITCH_WAIT: begin
            if (status.div_done) begin
               // keep pitch mean, launch yaw division
               cmd.take_pitch = 1'b1;
               cmd.div_start  = 1'b1;
               cmd.div_yaw    = 1'b1;
               state_in       = sgba_pkg::ST_YAW_WAIT;
            end
         end
         sgba_pkg::ST_YAW_WAIT: begin
            cmd.div_yaw = 1'b1;
            if (status.div_done) begin
               state_in = sgba_pkg::ST_PUBLISH;
            end
         end
         sgba_pkg::ST_PUBLISH: begin
            cmd.div_yaw = 1'b1;
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = sgba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sgba_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: src/stationary_gyro_bias_averager_top.sv
// a beat is loaded, then its pitch and yaw means are divided in turn and the result published
// a new beat is taken only once the last result is published, and publishing waits for a free
//   output register; the shared one-bit-per-cycle divider runs the pitch and yaw means back to back
// a finished result waits in the output register while the next beat is taken
// reset: synchronous, active high; limits return to defaults, sums, count and
//   last velocity clear, no result pending
// ----------------------------------------------------------------------------
// stationary_gyro_bias_averager_top
// zero-velocity cumulative average of pitch and yaw gyro rates
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stationary_gyro_bias_averager_top_assert.svh"

module stationary_gyro_bias_averager_top #(
   parameter int COUNT_BITS = sgba_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic [sgba_pkg::RATE_W-1:0]         req_velocity,
   input  logic [sgba_pkg::RATE_W-1:0]         req_pitch_rate,
   input  logic [sgba_pkg::RATE_W-1:0]         req_yaw_rate,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sgba_pkg::RATE_W-1:0]         rsp_pitch_average,
   output logic [sgba_pkg::RATE_W-1:0]         rsp_yaw_average,
   output logic [sgba_pkg::SAMPLE_W-1:0]       rsp_sample_count,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sgba_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sgba_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sgba_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   sgba_pkg::sgba_cmd_type    cmd;
   sgba_pkg::sgba_status_type status;

   assign csr_pready = 1'b1;

   // sequencer
   sgba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   sgba_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_velocity      (req_velocity),
      .req_pitch_rate    (req_pitch_rate),
      .req_yaw_rate      (req_yaw_rate),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pitch_average (rsp_pitch_average),
      .rsp_yaw_average   (rsp_yaw_average),
      .rsp_sample_count  (rsp_sample_count),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata)
   );

   // checks
   `SGBA_ASSERT_NEVER(a_no_accept_while_dividing, req_ready && status.div_busy, "beat taken during division")
   `SGBA_ASSERT_IMPLIES(a_publish_into_free, cmd.publish, !rsp_valid || rsp_ready, "result overwritten")
   `SGBA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "second beat taken at once")
   `SGBA_ASSERT_NEVER(a_start_while_busy, cmd.div_start && status.div_busy, "divider restarted mid-run")

endmodule

// File: dv/tb_stationary_gyro_bias_averager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stationary_gyro_bias_averager_top
// self-checking bench for the zero-velocity gyro bias averager
// ----------------------------------------------------------------------------
// Drives wheel and gyro beats over valid/ready with random gaps on both sides,
// reprograms the two limits over the register port between phases, and checks
// every result beat against an in-bench model of the running pitch and yaw
// averages. The block runs with its default count width.
// ----------------------------------------------------------------------------

module tb_stationary_gyro_bias_averager_top;

   // default count width, as the block is used
   localparam int CNT_W      = sgba_pkg::COUNT_BITS_DEF;
   localparam int LATENCY    = 2 * (32 + CNT_W) + 5;
   localparam int LONG_HOLD  = 600;
   localparam int PHASE_BEATS = 170;

   localparam logic [sgba_pkg::CSR_ADDR_W-1:0] VEL_ADDR = {sgba_pkg::CSR_VEL_LIMIT, 2'b00};
   localparam logic [sgba_pkg::CSR_ADDR_W-1:0] YAW_ADDR = {sgba_pkg::CSR_YAW_LIMIT, 2'b00};

   // ---------------------------------------------------------------------------
   // running-average model and queue of pending averages
   // ---------------------------------------------------------------------------
   class bias_scoreboard;
      typedef struct packed {
         logic [sgba_pkg::RATE_W-1:0]   pitch_avg;
         logic [sgba_pkg::RATE_W-1:0]   yaw_avg;
         logic [sgba_pkg::SAMPLE_W-1:0] count;
      } means_type;

      means_type                     expected_means[$];
      logic [sgba_pkg::LIMIT_W-1:0]  vel_lim;
      logic [sgba_pkg::LIMIT_W-1:0]  yaw_lim;
      logic signed [31:0]  held_vel;
      longint              pitch_acc;
      longint              yaw_acc;
      int unsigned         still_cnt;
      int unsigned         cnt_max;
      int unsigned         mismatches;
      int unsigned         n_wheel, n_gyro, n_still, n_clear, n_sat, n_results;

      function new(int unsigned max_count);
         cnt_max     = max_count;
         vel_lim     = sgba_pkg::VEL_LIMIT_RESET;
         yaw_lim     = sgba_pkg::YAW_LIMIT_RESET;
         held_vel    = '0;
         pitch_acc   = 0;
         yaw_acc     = 0;
         still_cnt   = 0;
         mismatches  = 0;
         n_wheel     = 0;
         n_gyro      = 0;
         n_still     = 0;
         n_clear     = 0;
         n_sat       = 0;
         n_results   = 0;
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      function void set_limit(logic idx, logic [31:0] data);
         if (idx == sgba_pkg::CSR_VEL_LIMIT) vel_lim = data[sgba_pkg::LIMIT_W-1:0];
         else yaw_lim = data[sgba_pkg::LIMIT_W-1:0];
      endfunction

      function longint abs_wide(longint v);
         return (v < 0) ? -v : v;
      endfunction

      // truncating signed mean, zero while nothing is accumulated
      function logic [sgba_pkg::RATE_W-1:0] average_q(longint acc);
         longint q;
         if (still_cnt == 0) return '0;
         q = abs_wide(acc) / longint'(still_cnt);
         if (acc < 0) q = -q;
         return q[sgba_pkg::RATE_W-1:0];
      endfunction

      function int unsigned pending();
         return expected_means.size();
      endfunction

      // one accepted input beat, one expected result
      function void note_beat(logic kind, logic [31:0] vel, logic [31:0] pitch,
                              logic [31:0] yaw);
         longint y;
         means_type e;
         if (kind == sgba_pkg::KIND_WHEEL) begin
            held_vel = vel;
            n_wheel++;
         end else begin
            n_gyro++;
            y = longint'($signed(yaw));
            if (abs_wide(longint'(held_vel)) < longint'(vel_lim) &&
                abs_wide(y) < longint'(yaw_lim)) begin
               if (still_cnt < cnt_max) begin
                  pitch_acc += longint'($signed(pitch));
                  yaw_acc   += y;
                  still_cnt++;
                  n_still++;
               end else begin
                  n_sat++;
               end
            end else begin
               pitch_acc = 0;
               yaw_acc   = 0;
               still_cnt = 0;
               n_clear++;
            end
         end
         e.pitch_avg = average_q(pitch_acc);
         e.yaw_avg   = average_q(yaw_acc);
         e.count     = still_cnt[sgba_pkg::SAMPLE_W-1:0];
         expected_means.push_back(e);
      endfunction

      task check_result(logic [sgba_pkg::RATE_W-1:0] pa, logic [sgba_pkg::RATE_W-1:0] ya,
                        logic [sgba_pkg::SAMPLE_W-1:0] cnt);
         means_type e;
         n_results++;
         if (expected_means.size() == 0) begin
            report($sformatf("unexpected result pitch %h yaw %h count %0d", pa, ya, cnt));
            return;
         end
         e = expected_means.pop_front();
         if (pa !== e.pitch_avg)
            report($sformatf("pitch_average %h, want %h", pa, e.pitch_avg));
         if (ya !== e.yaw_avg)
            report($sformatf("yaw_average %h, want %h", ya, e.yaw_avg));
         if (cnt !== e.count)
            report($sformatf("sample_count %0d, want %0d", cnt, e.count));
      endtask
   endclass

   // ---------------------------------------------------------------------------
   // signals and block under test
   // ---------------------------------------------------------------------------
   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid, req_ready, req_kind;
   logic [sgba_pkg::RATE_W-1:0]     req_velocity, req_pitch_rate, req_yaw_rate;
   logic                            rsp_valid, rsp_ready;
   logic [sgba_pkg::RATE_W-1:0]     rsp_pitch_average, rsp_yaw_average;
   logic [sgba_pkg::SAMPLE_W-1:0]   rsp_sample_count;
   logic                            csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [sgba_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [sgba_pkg::CSR_DATA_W-1:0] csr_pwdata, csr_prdata;

   bias_scoreboard                  sb = new((1 << CNT_W) - 1);
   logic [sgba_pkg::LIMIT_W-1:0]    cur_vel_lim = sgba_pkg::VEL_LIMIT_RESET;
   logic [sgba_pkg::LIMIT_W-1:0]    cur_yaw_lim = sgba_pkg::YAW_LIMIT_RESET;
   bit                              quiet = 1'b0;
   bit                              sender_gaps = 1'b1;
   bit                              hold_long = 1'b0;
   int unsigned                     n_phases = 0;

   stationary_gyro_bias_averager_top #(.COUNT_BITS(CNT_W)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_velocity      (req_velocity),
      .req_pitch_rate    (req_pitch_rate),
      .req_yaw_rate      (req_yaw_rate),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pitch_average (rsp_pitch_average),
      .rsp_yaw_average   (rsp_yaw_average),
      .rsp_sample_count  (rsp_sample_count),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // clock
   always #4 clock = ~clock;

   // input beat monitor
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_beat(req_kind, req_velocity, req_pitch_rate, req_yaw_rate);
   end

   // result beat monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_pitch_average, rsp_yaw_average, rsp_sample_count);
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         if (hold_long) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // register port
   // ---------------------------------------------------------------------------
   task automatic csr_access(logic wr, logic [sgba_pkg::CSR_ADDR_W-1:0] addr,
                             logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // return to idle between transfers
      @(posedge clock);
   endtask

   task automatic csr_check(logic [sgba_pkg::CSR_ADDR_W-1:0] addr,
                            logic [sgba_pkg::LIMIT_W-1:0] want);
      logic [31:0] rd;
      csr_access(1'b0, addr, '0, rd);
      if (rd !== {1'b0, want})
         sb.report($sformatf("register at %0d reads %h, want %h", addr, rd, want));
   endtask

   // write both limits (top bit random, it must be dropped) and read them back
   task automatic set_limits(logic [sgba_pkg::LIMIT_W-1:0] vel,
                             logic [sgba_pkg::LIMIT_W-1:0] yaw);
      logic [31:0] wd, rd;
      wd = {1'($urandom_range(0, 1)), vel};
      csr_access(1'b1, VEL_ADDR, wd, rd);
      sb.set_limit(sgba_pkg::CSR_VEL_LIMIT, wd);
      wd = {1'($urandom_range(0, 1)), yaw};
      csr_access(1'b1, YAW_ADDR, wd, rd);
      sb.set_limit(sgba_pkg::CSR_YAW_LIMIT, wd);
      cur_vel_lim = vel;
      cur_yaw_lim = yaw;
      csr_check(VEL_ADDR, vel);
      csr_check(YAW_ADDR, yaw);
      n_phases++;
   endtask

   // ---------------------------------------------------------------------------
   // input beats
   // ---------------------------------------------------------------------------
   task automatic offer_beat(logic kind, logic [31:0] vel, logic [31:0] pitch,
                             logic [31:0] yaw);
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_velocity   <= vel;
      req_pitch_rate <= pitch;
      req_yaw_rate   <= yaw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // sender gap burst
      if (sender_gaps && !quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // drop valid and let every pending result come back
   task automatic wait_idle(int unsigned settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // value whose magnitude is strictly below lim, any value when lim is zero
   function automatic logic [31:0] pick_below(logic [sgba_pkg::LIMIT_W-1:0] lim);
      logic [31:0] mag;
      if (lim == 0) return $urandom;
      if ($urandom_range(0, 7) == 0) mag = lim - 1;
      else if ($urandom_range(0, 1) == 0) mag = $urandom_range(0, lim - 1);
      else mag = $urandom_range(0, (lim > 256) ? 255 : lim - 1);
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   // values right at and around a limit
   function automatic logic [31:0] pick_edge(logic [sgba_pkg::LIMIT_W-1:0] lim);
      case ($urandom_range(0, 4))
         0: return {1'b0, lim};
         1: return -{1'b0, lim};
         2: return {1'b0, lim} - 1;
         3: return 1 - {1'b0, lim};
         default: return 32'h8000_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_rate();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2, 3: return $urandom;
         default: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 18)
                                              : -$urandom_range(0, 1 << 18);
      endcase
   endfunction

   // mostly stationary runs with random content, the rest noise and breaks
   task automatic run_random(int unsigned beats);
      int unsigned done;
      int unsigned run_len;
      done = 0;
      while (done < beats) begin
         if ($urandom_range(0, 9) < 7) begin
            offer_beat(sgba_pkg::KIND_WHEEL, pick_below(cur_vel_lim), $urandom, $urandom);
            run_len = $urandom_range(1, 22);
            repeat (run_len) begin
               if ($urandom_range(0, 11) == 0)
                  offer_beat(sgba_pkg::KIND_GYRO, $urandom, pick_rate(),
                             pick_edge(cur_yaw_lim));
               else
                  offer_beat(sgba_pkg::KIND_GYRO, $urandom, pick_rate(),
                             pick_below(cur_yaw_lim));
            end
            done += run_len + 1;
         end else begin
            case ($urandom_range(0, 2))
               0: offer_beat(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
               1: offer_beat(sgba_pkg::KIND_WHEEL, pick_edge(cur_vel_lim), $urandom, $urandom);
               default: offer_beat(sgba_pkg::KIND_GYRO, $urandom, pick_rate(),
                                   pick_edge(cur_yaw_lim));
            endcase
            done++;
         end
      end
   endtask

   // directed beats under the reset limits
   task automatic run_directed();
      // stationary with extreme pitch, yaw just inside the limit
      offer_beat(sgba_pkg::KIND_GYRO, 32'h0, 32'h7FFF_FFFF, 32'h0);
      offer_beat(sgba_pkg::KIND_GYRO, 32'hFFFF_FFFF, 32'h8000_0000, 32'd32767);
      offer_beat(sgba_pkg::KIND_GYRO, 32'h0, -32'd5, -32'd32767);
      // yaw at the limit and most negative yaw clear the run
      offer_beat(sgba_pkg::KIND_GYRO, 32'h0, 32'd9, 32'd32768);
      offer_beat(sgba_pkg::KIND_GYRO, 32'h0, 32'd9, 32'h8000_0000);
      // moving: largest, most negative and unit velocity all block
      offer_beat(sgba_pkg::KIND_WHEEL, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_beat(sgba_pkg::KIND_GYRO, 32'h0, 32'd1, 32'h0);
      offer_beat(sgba_pkg::KIND_WHEEL, 32'h8000_0000, 32'h0, 32'h0);
      offer_beat(sgba_pkg::KIND_GYRO, 32'hFFFF_FFFF, 32'd1, 32'h0);
      offer_beat(sgba_pkg::KIND_WHEEL, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
      offer_beat(sgba_pkg::KIND_GYRO, 32'h0, 32'd1, 32'h0);
      offer_beat(sgba_pkg::KIND_WHEEL, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555);
      // long stationary run with large and mixed-sign rates
      for (int i = 0; i < 17; i++)
         offer_beat(sgba_pkg::KIND_GYRO, 32'h0, (i % 2) ? 32'h7FFF_FFFF - i : -32'd7 * i,
                    -32'd1000 * i);
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_kind       <= sgba_pkg::KIND_WHEEL;
      req_velocity   <= '0;
      req_pitch_rate <= '0;
      req_yaw_rate   <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values, then directed beats
      csr_check(VEL_ADDR, sgba_pkg::VEL_LIMIT_RESET);
      csr_check(YAW_ADDR, sgba_pkg::YAW_LIMIT_RESET);
      n_phases++;
      run_directed();
      run_random(PHASE_BEATS - 30);
      wait_idle(4);

      // zero velocity limit: nothing is ever stationary
      set_limits('0, 31'($urandom_range(1, 1 << 20)));
      run_random(PHASE_BEATS);
      wait_idle(4);

      // widest velocity window, yaw limit zero
      set_limits(31'h7FFF_FFFF, '0);
      run_random(PHASE_BEATS);
      wait_idle(4);

      // both limits wide open, receiver holds off while beats keep coming
      set_limits(31'h7FFF_FFFF, 31'h7FFF_FFFF);
      hold_long   = 1'b1;
      sender_gaps = 1'b0;
      repeat (8) offer_beat(sgba_pkg::KIND_GYRO, $urandom, pick_rate(), pick_rate());
      sender_gaps = 1'b1;
      run_random(PHASE_BEATS);
      wait_idle(4);

      set_limits(31'($urandom), 31'($urandom));
      run_random(PHASE_BEATS);
      wait_idle(4);

      set_limits(31'd1 << 16, 31'($urandom_range(1, 1 << 16)));
      run_random(PHASE_BEATS);
      wait_idle(4);

      // last stretch with no idling on either side
      set_limits(31'($urandom_range(1, 1 << 24)), 31'($urandom_range(1, 1 << 24)));
      quiet = 1'b1;
      run_random(PHASE_BEATS);
      wait_idle(LATENCY + 20);

      $display("covered %0d wheel and %0d gyro beats over %0d limit settings",
               sb.n_wheel, sb.n_gyro, n_phases);
      $display("stationary samples %0d, run clears %0d, saturated samples %0d, results %0d",
               sb.n_still, sb.n_clear, sb.n_sat, sb.n_results);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
